>>> hdl/ssr_pkg.sv
// Shared types, constants and goal arithmetic for the six-channel servo slew ramp.
// No dependencies; used by servo_slew_ramp_six_channel_top.
package ssr_pkg;

    localparam int unsigned NUM_CH     = 6;
    localparam int unsigned RAMPED     = 4;
    localparam int unsigned PULSE_BITS = 11;
    localparam int unsigned ANGLE_BITS = 13;
    localparam int unsigned CHAN_BITS  = 3;
    localparam int unsigned BAND_BITS  = 5;
    localparam int unsigned STEP_BITS  = 32;
    localparam int unsigned OFFS_BITS  = 48;
    localparam int unsigned CFG_BITS   = 48;
    localparam int unsigned CFG_ADDR_BITS = 3;
    localparam int unsigned OUT_BYTES  = (NUM_CH * PULSE_BITS + 7) / 8;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_STEP       = 3'd0,
        CFG_OFFSET     = 3'd1,
        CFG_NEAR_BAND  = 3'd2,
        CFG_CENTER     = 3'd3,
        CFG_LIMIT_LOW  = 3'd4,
        CFG_LIMIT_HIGH = 3'd5,
        CFG_GRIP_LOW   = 3'd6,
        CFG_GRIP_HIGH  = 3'd7
    } cfg_addr_t;

    // item commands
    localparam logic CMD_SET_GOAL = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // reset values of the registers
    localparam logic [STEP_BITS-1:0]  STEP_RESET   = 32'h140D_0507;
    localparam logic [OFFS_BITS-1:0]  OFFSET_RESET = 48'h0000_CE00_14E7;
    localparam logic [BAND_BITS-1:0]  BAND_RESET   = 5'd5;
    localparam logic [PULSE_BITS-1:0] CENTER_RESET = 11'd700;
    localparam logic [PULSE_BITS-1:0] LOW_RESET    = 11'd200;
    localparam logic [PULSE_BITS-1:0] HIGH_RESET   = 11'd1200;
    localparam logic [PULSE_BITS-1:0] GLOW_RESET   = 11'd450;
    localparam logic [PULSE_BITS-1:0] GHIGH_RESET  = 11'd1000;

    // angle bias that keeps the divide-by-three operand positive; a multiple of three
    localparam int unsigned ANGLE_BIAS = 4098;
    localparam int unsigned RECIP3     = 43691;   // ceil(2^17 / 3)
    localparam int unsigned RECIP3_SH  = 17;

    typedef logic [NUM_CH-1:0][PULSE_BITS-1:0] pulse_vec_t;

    typedef struct packed {
        logic                         cmd;
        logic [CHAN_BITS-1:0]         channel;
        logic signed [ANGLE_BITS-1:0] angle;
    } item_t;

    // ramp step of a channel, zero for channels that jump
    function automatic logic [7:0] step_byte(logic [STEP_BITS-1:0] tbl, int unsigned idx);
        if (idx >= RAMPED || idx >= STEP_BITS / 8) begin
            return 8'd0;
        end
        return 8'(tbl >> (8 * idx));
    endfunction

    // signed pulse offset of a channel
    function automatic logic signed [7:0] offset_byte(logic [OFFS_BITS-1:0] tbl,
                                                      int unsigned idx);
        if (idx >= OFFS_BITS / 8) begin
            return 8'sd0;
        end
        return 8'(tbl >> (8 * idx));
    endfunction

    // floor(angle/3) + centre + offset, clamped high first then low
    function automatic logic [PULSE_BITS-1:0] goal_calc(
        logic signed [ANGLE_BITS-1:0] angle,
        logic [PULSE_BITS-1:0]        center,
        logic signed [7:0]            offs,
        logic [PULSE_BITS-1:0]        lo,
        logic [PULSE_BITS-1:0]        hi
    );
        logic [13:0]        biased;
        logic [29:0]        prod;
        logic signed [13:0] quo;
        logic signed [13:0] sum;
        biased = 14'(14'(signed'(angle)) + 14'(ANGLE_BIAS));
        prod   = 30'(biased) * 30'(RECIP3);
        quo    = 14'(prod >> RECIP3_SH) - 14'(ANGLE_BIAS / 3);
        sum    = quo + signed'({3'b000, center}) + 14'(offs);
        if (sum > signed'({3'b000, hi})) begin
            sum = signed'({3'b000, hi});
        end
        if (sum < signed'({3'b000, lo})) begin
            sum = signed'({3'b000, lo});
        end
        return sum[PULSE_BITS-1:0];
    endfunction

endpackage

>>> hdl/servo_slew_ramp_six_channel_top.sv
// Six-channel servo slew ramp: goal registers, ramp logic and stream ports.
// Depends on ssr_pkg for types, register indexes and the goal arithmetic.
//
// Usage
//   The slave stream carries commands: s_tuser is the command (set goal or tick),
//   s_tdata holds the channel and a signed angle in sixteenths of a degree.
//   A set goal updates one channel's goal pulse and returns nothing; a goal for
//   channel 6 or 7 is dropped. A tick steps channels 0..3 toward their goals
//   (by their step, or by one when close) and moves channels 4 and 5 straight
//   to their goals, then returns all six pulses as one transfer on the master side.
//   Each transfer is caught in an input register and handled from there; a tick's
//   result is registered in the pulse registers and presented straight from
//   them. One item per cycle is taken back to back, unless a tick has to wait
//   for a stalled receiver.
//   When the receiver stalls, a result waits in place; set goals keep flowing,
//   and a further tick waits in the input register until the result is taken.
//   Write registers through the cfg port only while the block is idle; the block
//   does not enforce it. Reset (aresetn low, synchronous) restores the register
//   defaults, sets every pulse to the centre and every goal to its zero-angle value.
module servo_slew_ramp_six_channel_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // command stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [15:0]                           s_tdata,   // channel[2:0], angle[15:3]
    input  logic [0:0]                            s_tuser,   // cmd[0]
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [ssr_pkg::OUT_BYTES*8-1:0]       m_tdata,   // pulse_turn, pulse_big,
                                                             // pulse_medium, pulse_small,
                                                             // pulse_wrist, pulse_grip
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [ssr_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [ssr_pkg::CFG_BITS-1:0]          cfg_wr_data
);

    localparam int unsigned NCH = ssr_pkg::NUM_CH;
    localparam int unsigned PB  = ssr_pkg::PULSE_BITS;

    // configuration registers
    logic [ssr_pkg::STEP_BITS-1:0] step_reg;
    logic [ssr_pkg::OFFS_BITS-1:0] offset_reg;
    logic [ssr_pkg::BAND_BITS-1:0] band_reg;
    logic [PB-1:0]                 center_reg;
    logic [PB-1:0]                 low_reg;
    logic [PB-1:0]                 high_reg;
    logic [PB-1:0]                 glow_reg;
    logic [PB-1:0]                 ghigh_reg;

    // input stage
    logic           in_valid_reg;
    ssr_pkg::item_t in_item_reg;

    // servo state
    ssr_pkg::pulse_vec_t cur_reg;
    ssr_pkg::pulse_vec_t goal_reg;
    ssr_pkg::pulse_vec_t ramp_next;
    logic                out_valid_reg;

    logic          out_free;
    logic          adv;
    logic          adv_tick;
    logic          adv_goal;
    logic [PB-1:0] goal_new;
    logic          is_grip;

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign adv      = in_valid_reg && ((in_item_reg.cmd == ssr_pkg::CMD_SET_GOAL) || out_free);
    assign adv_tick = adv && (in_item_reg.cmd == ssr_pkg::CMD_TICK);
    assign adv_goal = adv && (in_item_reg.cmd == ssr_pkg::CMD_SET_GOAL)
                      && (32'(in_item_reg.channel) < NCH);
    assign s_tready = !in_valid_reg || adv;

    // goal for a set-goal item
    assign is_grip  = (32'(in_item_reg.channel) == NCH - 1);
    assign goal_new = ssr_pkg::goal_calc(in_item_reg.angle, center_reg,
                          ssr_pkg::offset_byte(offset_reg, 32'(in_item_reg.channel)),
                          is_grip ? glow_reg : low_reg,
                          is_grip ? ghigh_reg : high_reg);

    // ramp each channel toward its goal
    always_comb begin
        logic [PB-1:0] cur;
        logic [PB-1:0] goal;
        logic [PB-1:0] gap;
        logic [PB-1:0] mv;
        logic [7:0]    st;
        logic [9:0]    near_lim;
        for (int unsigned i = 0; i < NCH; i++) begin
            cur      = cur_reg[i];
            goal     = goal_reg[i];
            st       = ssr_pkg::step_byte(step_reg, i);
            gap      = (goal > cur) ? (goal - cur) : (cur - goal);
            near_lim = 10'(st) + 10'(band_reg);
            mv       = (32'(gap) < 32'(near_lim)) ? PB'(1) : PB'(st);
            if (i >= ssr_pkg::RAMPED) begin
                ramp_next[i] = goal;
            end else if (cur == goal) begin
                ramp_next[i] = cur;
            end else if (goal > cur) begin
                ramp_next[i] = cur + mv;
            end else begin
                ramp_next[i] = cur - mv;
            end
        end
    end

    // registers, input stage and servo state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ssr_pkg::STEP_RESET;
            offset_reg    <= ssr_pkg::OFFSET_RESET;
            band_reg      <= ssr_pkg::BAND_RESET;
            center_reg    <= ssr_pkg::CENTER_RESET;
            low_reg       <= ssr_pkg::LOW_RESET;
            high_reg      <= ssr_pkg::HIGH_RESET;
            glow_reg      <= ssr_pkg::GLOW_RESET;
            ghigh_reg     <= ssr_pkg::GHIGH_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int unsigned i = 0; i < NCH; i++) begin
                cur_reg[i]  <= ssr_pkg::CENTER_RESET;
                goal_reg[i] <= ssr_pkg::goal_calc('0, ssr_pkg::CENTER_RESET,
                                   ssr_pkg::offset_byte(ssr_pkg::OFFSET_RESET, i),
                                   (i == NCH - 1) ? ssr_pkg::GLOW_RESET : ssr_pkg::LOW_RESET,
                                   (i == NCH - 1) ? ssr_pkg::GHIGH_RESET : ssr_pkg::HIGH_RESET);
            end
        end else begin
            // register writes
            if (cfg_wr_en) begin
                unique case (ssr_pkg::cfg_addr_t'(cfg_addr))
                    ssr_pkg::CFG_STEP:       step_reg   <= cfg_wr_data[ssr_pkg::STEP_BITS-1:0];
                    ssr_pkg::CFG_OFFSET:     offset_reg <= cfg_wr_data[ssr_pkg::OFFS_BITS-1:0];
                    ssr_pkg::CFG_NEAR_BAND:  band_reg   <= cfg_wr_data[ssr_pkg::BAND_BITS-1:0];
                    ssr_pkg::CFG_CENTER:     center_reg <= cfg_wr_data[PB-1:0];
                    ssr_pkg::CFG_LIMIT_LOW:  low_reg    <= cfg_wr_data[PB-1:0];
                    ssr_pkg::CFG_LIMIT_HIGH: high_reg   <= cfg_wr_data[PB-1:0];
                    ssr_pkg::CFG_GRIP_LOW:   glow_reg   <= cfg_wr_data[PB-1:0];
                    ssr_pkg::CFG_GRIP_HIGH:  ghigh_reg  <= cfg_wr_data[PB-1:0];
                    default:                 step_reg   <= step_reg;
                endcase
            end
            // input stage
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            // set goal
            if (adv_goal) begin
                goal_reg[in_item_reg.channel] <= goal_new;
            end
            // tick: step the pulses and present them
            if (adv_tick) begin
                cur_reg       <= ramp_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.cmd     <= s_tuser[0];
            in_item_reg.channel <= s_tdata[ssr_pkg::CHAN_BITS-1:0];
            in_item_reg.angle   <= s_tdata[ssr_pkg::CHAN_BITS +: ssr_pkg::ANGLE_BITS];
        end
    end

    // result stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(ssr_pkg::OUT_BYTES*8 - NCH*PB)'(0), cur_reg};

`ifndef ASSERT_OFF
    // a result only ever follows a tick
    a_out_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(adv_tick))
        else $error("result raised without a tick");

    // a set goal never moves the pulses
    a_goal_keeps_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !adv_tick) |=> $stable(cur_reg))
        else $error("set goal changed a pulse");

    // the last channel lands on its goal at every tick
    a_jump_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_tick |=> (cur_reg[NCH-1] == $past(goal_reg[NCH-1])))
        else $error("jump channel missed its goal");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for servo_slew_ramp_six_channel_top: set-goal and tick commands,
// register settings from defaults to extremes, random source gaps and sink stalls.
// Depends on ssr_pkg and hdl/servo_slew_ramp_six_channel_top.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ssr_pkg::*;

    // predicts the six pulse registers and holds the pulse sets still to come
    class pulse_scoreboard;
        logic [STEP_BITS-1:0]  step_tbl;
        logic [OFFS_BITS-1:0]  offs_tbl;
        logic [BAND_BITS-1:0]  band;
        logic [PULSE_BITS-1:0] center, lim_lo, lim_hi, grip_lo, grip_hi;
        int                    cur_pulse[NUM_CH];
        int                    goal_pulse[NUM_CH];
        string                 chan_name[NUM_CH];
        pulse_vec_t            expected_pulses[$];
        int                    errors, checked, ticks, commands;

        function new();
            chan_name = '{"pulse_turn", "pulse_big", "pulse_medium",
                          "pulse_small", "pulse_wrist", "pulse_grip"};
            step_tbl = STEP_RESET;
            offs_tbl = OFFSET_RESET;
            band     = BAND_RESET;
            center   = CENTER_RESET;
            lim_lo   = LOW_RESET;
            lim_hi   = HIGH_RESET;
            grip_lo  = GLOW_RESET;
            grip_hi  = GHIGH_RESET;
            for (int i = 0; i < NUM_CH; i++) begin
                cur_pulse[i]  = int'(CENTER_RESET);
                goal_pulse[i] = goal_for(i, 0);
            end
        endfunction

        // floor(angle/3) + centre + signed offset, high clamp then low clamp
        function int goal_for(int ch, int angle);
            logic [7:0] offs_byte;
            int quot, offs, sum, lo, hi;
            offs_byte = offs_tbl[8*ch +: 8];
            offs = int'($signed(offs_byte));
            quot = (angle >= 0) ? angle / 3 : -((-angle + 2) / 3);
            sum  = quot + int'(center) + offs;
            if (ch == NUM_CH - 1) begin
                lo = int'(grip_lo);
                hi = int'(grip_hi);
            end else begin
                lo = int'(lim_lo);
                hi = int'(lim_hi);
            end
            if (sum > hi) begin
                sum = hi;
            end
            if (sum < lo) begin
                sum = lo;
            end
            return sum;
        endfunction

        function void write_reg(cfg_addr_t idx, logic [CFG_BITS-1:0] value);
            case (idx)
                CFG_STEP:       step_tbl = value[STEP_BITS-1:0];
                CFG_OFFSET:     offs_tbl = value[OFFS_BITS-1:0];
                CFG_NEAR_BAND:  band     = value[BAND_BITS-1:0];
                CFG_CENTER:     center   = value[PULSE_BITS-1:0];
                CFG_LIMIT_LOW:  lim_lo   = value[PULSE_BITS-1:0];
                CFG_LIMIT_HIGH: lim_hi   = value[PULSE_BITS-1:0];
                CFG_GRIP_LOW:   grip_lo  = value[PULSE_BITS-1:0];
                CFG_GRIP_HIGH:  grip_hi  = value[PULSE_BITS-1:0];
                default: ;
            endcase
        endfunction

        // accepted command: set a goal, or ramp every channel and expect the pulses
        function void note_command(logic cmd, logic [CHAN_BITS-1:0] ch,
                                   logic signed [ANGLE_BITS-1:0] angle);
            pulse_vec_t pulses;
            int st, gap, mv;
            commands++;
            if (cmd == CMD_SET_GOAL) begin
                if (ch < NUM_CH) begin
                    goal_pulse[ch] = goal_for(int'(ch), int'(angle));
                end
            end else begin
                ticks++;
                for (int i = 0; i < NUM_CH; i++) begin
                    if (i >= RAMPED) begin
                        cur_pulse[i] = goal_pulse[i];
                    end else if (cur_pulse[i] != goal_pulse[i]) begin
                        st   = int'(step_tbl[8*i +: 8]);
                        gap  = (goal_pulse[i] > cur_pulse[i]) ? goal_pulse[i] - cur_pulse[i]
                                                              : cur_pulse[i] - goal_pulse[i];
                        mv   = (gap < st + int'(band)) ? 1 : st;
                        cur_pulse[i] += (goal_pulse[i] > cur_pulse[i]) ? mv : -mv;
                    end
                    pulses[i] = PULSE_BITS'(cur_pulse[i]);
                end
                expected_pulses.push_back(pulses);
            end
        endfunction

        function void check_pulses(logic [OUT_BYTES*8-1:0] data);
            pulse_vec_t want;
            if (expected_pulses.size() == 0) begin
                errors++;
                $display("%0t: result transfer with none pending, data 0x%h", $time, data);
            end else begin
                want = expected_pulses.pop_front();
                checked++;
                for (int i = 0; i < NUM_CH; i++) begin
                    if (data[i*PULSE_BITS +: PULSE_BITS] !== want[i]) begin
                        errors++;
                        $display("%0t: %s expected %0d actual %0d", $time, chan_name[i],
                                 want[i], data[i*PULSE_BITS +: PULSE_BITS]);
                    end
                end
            end
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [15:0]                  s_tdata = '0;     // channel[2:0], angle[15:3]
    logic [0:0]                   s_tuser = '0;     // cmd[0]
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [OUT_BYTES*8-1:0]       m_tdata;          // pulse_turn .. pulse_grip, 11 bits each
    logic                         cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0]     cfg_addr = '0;
    logic [CFG_BITS-1:0]          cfg_wr_data = '0;

    int                           idle_pct = 0;
    int                           stall_pct = 0;
    int                           settings = 1;
    pulse_scoreboard              sb = new();

    servo_slew_ramp_six_channel_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    always #6 aclk = ~aclk;

    // sink stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // transfer monitor on both streams
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_pulses(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_command(s_tuser[0], s_tdata[2:0], s_tdata[15:3]);
            end
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("servo_slew_ramp_six_channel_top: mismatch");
        $finish;
    end

    // one command transfer, with random source gaps before it
    task automatic send_cmd(logic cmd, logic [CHAN_BITS-1:0] ch,
                            logic signed [ANGLE_BITS-1:0] angle);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {angle, ch};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic random_cmd();
        int pick;
        int angle;
        pick  = $urandom_range(99);
        angle = ($urandom_range(9) == 0) ? (($urandom_range(1) == 1) ? 2880 : -2880)
                                         : int'($urandom_range(5760)) - 2880;
        if (pick < 45) begin
            send_cmd(CMD_TICK, CHAN_BITS'($urandom_range(7)), ANGLE_BITS'(angle));
        end else if (pick < 95) begin
            send_cmd(CMD_SET_GOAL, CHAN_BITS'($urandom_range(NUM_CH - 1)), ANGLE_BITS'(angle));
        end else begin
            send_cmd(CMD_SET_GOAL, CHAN_BITS'($urandom_range(7, NUM_CH)), ANGLE_BITS'(angle));
        end
    endtask

    // stop sending and let every pending result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_pulses.size() != 0) begin
            @(posedge aclk);
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_BITS-1:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= cfg_addr_t'(i);
            cfg_wr_data <= vals[i];
            sb.write_reg(cfg_addr_t'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [CFG_BITS-1:0] regs [8];
        int lo;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: angle extremes, rounding of negatives, gripper limits, dropped channels
        send_cmd(CMD_TICK, 3'd0, 13'sd0);
        send_cmd(CMD_SET_GOAL, 3'd0, 13'sd2880);
        send_cmd(CMD_SET_GOAL, 3'd1, -13'sd2880);
        send_cmd(CMD_SET_GOAL, 3'd2, -13'sd1);
        send_cmd(CMD_SET_GOAL, 3'd3, -13'sd2);
        send_cmd(CMD_SET_GOAL, 3'd4, -13'sd3);
        send_cmd(CMD_SET_GOAL, 3'd5, 13'sd2880);
        send_cmd(CMD_TICK, 3'd7, -13'sd1);
        send_cmd(CMD_TICK, 3'd0, 13'sd0);
        send_cmd(CMD_SET_GOAL, 3'd6, 13'sd600);
        send_cmd(CMD_SET_GOAL, 3'd7, -13'sd2880);
        send_cmd(CMD_SET_GOAL, 3'd5, -13'sd2880);
        send_cmd(CMD_TICK, 3'd0, 13'sd0);
        send_cmd(CMD_SET_GOAL, 3'd2, 13'sd1);
        send_cmd(CMD_SET_GOAL, 3'd3, 13'sd4);
        send_cmd(CMD_TICK, 3'd0, 13'sd0);
        send_cmd(CMD_TICK, 3'd0, 13'sd0);
        send_cmd(CMD_SET_GOAL, 3'd0, 13'sd0);
        send_cmd(CMD_TICK, 3'd5, 13'sd2880);
        send_cmd(CMD_TICK, 3'd0, 13'sd0);
        settle();

        // register settings: defaults, two sets of extremes, then random ones
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    regs[CFG_STEP]       = 48'hFFFF_FFFF;
                    regs[CFG_OFFSET]     = 48'h7F7F_7F7F_7F7F;
                    regs[CFG_NEAR_BAND]  = 48'd31;
                    regs[CFG_CENTER]     = 48'd2047;
                    regs[CFG_LIMIT_LOW]  = 48'd0;
                    regs[CFG_LIMIT_HIGH] = 48'd2047;
                    regs[CFG_GRIP_LOW]   = 48'd0;
                    regs[CFG_GRIP_HIGH]  = 48'd2047;
                end
                2: begin
                    // zero steps, crossed limits, sums below zero
                    regs[CFG_STEP]       = 48'h0001_00FF;
                    regs[CFG_OFFSET]     = 48'h8080_8080_8080;
                    regs[CFG_NEAR_BAND]  = 48'd0;
                    regs[CFG_CENTER]     = 48'd0;
                    regs[CFG_LIMIT_LOW]  = 48'd1500;
                    regs[CFG_LIMIT_HIGH] = 48'd300;
                    regs[CFG_GRIP_LOW]   = 48'd0;
                    regs[CFG_GRIP_HIGH]  = 48'd2047;
                end
                3, 4: begin
                    regs[CFG_STEP]       = (phase == 3) ? 48'($urandom)
                                                        : 48'($urandom & 32'h1F1F_1F1F);
                    regs[CFG_OFFSET]     = {16'($urandom), 32'($urandom)};
                    regs[CFG_NEAR_BAND]  = 48'($urandom_range(31));
                    regs[CFG_CENTER]     = (phase == 3) ? 48'($urandom_range(400, 1000))
                                                        : 48'($urandom_range(2047));
                    lo                   = $urandom_range(900);
                    regs[CFG_LIMIT_LOW]  = 48'(lo);
                    regs[CFG_LIMIT_HIGH] = 48'($urandom_range(2047, lo));
                    lo                   = $urandom_range(900);
                    regs[CFG_GRIP_LOW]   = 48'(lo);
                    regs[CFG_GRIP_HIGH]  = 48'($urandom_range(2047, lo));
                end
                default: ;
            endcase
            if (phase > 0) begin
                program_regs(regs);
                settings++;
            end
            // idling: none, source gaps, sink stalls, both
            for (int mode = 0; mode < 4; mode++) begin
                idle_pct  = (mode == 1) ? 62 : (mode == 3) ? 28 : 0;
                stall_pct = (mode == 2) ? 62 : (mode == 3) ? 28 : 0;
                repeat (50) random_cmd();
            end
            settle();
        end

        $display("covered %0d commands (%0d ticks) under %0d register settings",
                 sb.commands, sb.ticks, settings);
        $display("checked %0d pulse sets, %0d field errors", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.expected_pulses.size() == 0) begin
            $display("servo_slew_ramp_six_channel_top: match");
        end else begin
            $display("servo_slew_ramp_six_channel_top: mismatch");
        end
        $finish;
    end

endmodule
